// ===== hdl/cdq_pkg.sv =====
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;
   localparam int FUNC_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = 1'b0;

   // status carried alongside the ram read
   typedef struct packed {
      logic             ok;
      logic [CAP_W-1:0] held;
      logic             full;
      logic             head_fwd;
      logic             tail_fwd;
   } stage_type;

endpackage

// ===== hdl/circular_deque.sv =====
// a result passes the read stage and then the result register on its way to rsp
// throughput: one request per cycle unless rsp stalls; the pointer and count
//   registers and ram write port are read, modified and written per request
// reset: capacity 16, deque empty; the slot ram is not cleared and needs no
//   clearing pass, as an entry is read only after a push has written it
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cdq_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [cdq_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [cdq_pkg::CAP_W-1:0]           rsp_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_head_value,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_tail_value,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cdq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cdq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = cdq_pkg::CAP_W;
   localparam int DW = cdq_pkg::DATA_W;
   localparam int IW = ((PW > CW) ? PW : CW) + 1;

   function automatic logic [CW-1:0] eff_cap(input logic [CW-1:0] cap);
      logic [CW-1:0] res;
      if (cap == '0) begin
         res = CW'(1);
      end else if (IW'(cap) > IW'(DEPTH)) begin
         res = CW'(DEPTH);
      end else begin
         res = cap;
      end
      return res;
   endfunction

   function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] i,
                                              input logic [CW-1:0] c);
      logic [IW-1:0] nxt;
      nxt = IW'(i) + IW'(1);
      return (nxt >= IW'(c)) ? '0 : PW'(nxt);
   endfunction

   function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] i,
                                              input logic [CW-1:0] c);
      logic [IW-1:0] cm1;
      cm1 = IW'(c) - IW'(1);
      return (i == '0 || IW'(i) >= IW'(c)) ? PW'(cm1) : i - PW'(1);
   endfunction

   // pointer state
   logic [CW-1:0] capacity_ff;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] eff_cap_w;

   // ram side
   logic          slot_wr;
   logic [PW-1:0] wr_addr;
   logic [PW-1:0] head_rd_addr;
   logic [PW-1:0] tail_rd_addr;
   logic [DW-1:0] head_rd_data;
   logic [DW-1:0] tail_rd_data;

   // stage after the ram read
   logic                 s1_vld_ff, s1_vld_in;
   cdq_pkg::stage_type   s1_ff, s1_in;
   logic [DW-1:0]        s1_push_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff;
   logic [CW-1:0]        rsp_count_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_full_ff;
   logic [DW-1:0]        rsp_head_ff, rsp_head_in;
   logic [DW-1:0]        rsp_tail_ff, rsp_tail_in;

   logic accept;
   logic out_free;
   logic cfg_wr;
   logic op_ok;

   assign eff_cap_w = eff_cap(capacity_ff);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[cdq_pkg::CSR_ADDR_W-1:2] == cdq_pkg::REG_CAPACITY);

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[cdq_pkg::CSR_ADDR_W-1:2] == cdq_pkg::REG_CAPACITY) ?
                       cdq_pkg::CSR_DATA_W'(capacity_ff) : '0;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      held_in = held_ff;
      op_ok   = 1'b0;
      slot_wr = 1'b0;
      wr_addr = head_ff;
      unique case (req_func)
         cdq_pkg::FUNC_PUSH_FRONT: begin
            if (held_ff < eff_cap_w) begin
               slot_wr = 1'b1;
               wr_addr = head_ff;
               head_in = ring_dec(head_ff, eff_cap_w);
               held_in = held_ff + CW'(1);
               op_ok   = 1'b1;
            end
         end
         cdq_pkg::FUNC_PUSH_REAR: begin
            if (held_ff < eff_cap_w) begin
               slot_wr = 1'b1;
               wr_addr = tail_ff;
               tail_in = ring_inc(tail_ff, eff_cap_w);
               held_in = held_ff + CW'(1);
               op_ok   = 1'b1;
            end
         end
         cdq_pkg::FUNC_POP_FRONT: begin
            if (held_ff != '0) begin
               head_in = ring_inc(head_ff, eff_cap_w);
               held_in = held_ff - CW'(1);
               op_ok   = 1'b1;
            end
         end
         cdq_pkg::FUNC_POP_REAR: begin
            if (held_ff != '0) begin
               tail_in = ring_dec(tail_ff, eff_cap_w);
               held_in = held_ff - CW'(1);
               op_ok   = 1'b1;
            end
         end
         cdq_pkg::FUNC_QUERY: begin
            op_ok = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign head_rd_addr = ring_inc(head_in, eff_cap_w);
   assign tail_rd_addr = ring_dec(tail_in, eff_cap_w);

   // the ram returns old data when read and written at the same address
   always_comb begin
      s1_in.ok       = op_ok;
      s1_in.held     = held_in;
      s1_in.full     = (held_in == eff_cap_w);
      s1_in.head_fwd = slot_wr && (wr_addr == head_rd_addr);
      s1_in.tail_fwd = slot_wr && (wr_addr == tail_rd_addr);
   end

   assign s1_vld_in    = accept ? 1'b1 : (out_free ? 1'b0 : s1_vld_ff);
   assign rsp_valid_in = out_free ? s1_vld_ff : rsp_valid_ff;

   always_comb begin
      if (s1_ff.held == '0) begin
         rsp_head_in = cdq_pkg::EMPTY_VALUE;
         rsp_tail_in = cdq_pkg::EMPTY_VALUE;
      end else begin
         rsp_head_in = s1_ff.head_fwd ? s1_push_ff : head_rd_data;
         rsp_tail_in = s1_ff.tail_fwd ? s1_push_ff : tail_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= cdq_pkg::CAP_RESET;
         head_ff      <= ring_dec('0, eff_cap(cdq_pkg::CAP_RESET));
         tail_ff      <= '0;
         held_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            capacity_ff <= csr_pwdata[CW-1:0];
            head_ff     <= ring_dec('0, eff_cap(csr_pwdata[CW-1:0]));
            tail_ff     <= '0;
            held_ff     <= '0;
         end else if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            held_ff <= held_in;
         end
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= s1_in;
         s1_push_ff <= req_value;
      end
      if (out_free && s1_vld_ff) begin
         rsp_ok_ff    <= s1_ff.ok;
         rsp_count_ff <= s1_ff.held;
         rsp_empty_ff <= (s1_ff.held == '0);
         rsp_full_ff  <= s1_ff.full;
         rsp_head_ff  <= rsp_head_in;
         rsp_tail_ff  <= rsp_tail_in;
      end
   end

   // two copies of the slots, one read port each for head and tail
   cdq_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (accept && slot_wr),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (accept),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   cdq_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (accept && slot_wr),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (accept),
      .rd_addr (tail_rd_addr),
      .rd_data (tail_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;
   assign rsp_head_value = $signed(rsp_head_ff);
   assign rsp_tail_value = $signed(rsp_tail_ff);

`ifndef SYNTHESIS
   a_held_in_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= eff_cap_w)
      else $error("element count above capacity");

   a_gaps_in_ring: assert property (@(posedge clock) disable iff (reset)
      (IW'(head_ff) < IW'(eff_cap_w)) && (IW'(tail_ff) < IW'(eff_cap_w)))
      else $error("ring index outside capacity");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg_wr && held_ff < eff_cap_w &&
       (req_func == cdq_pkg::FUNC_PUSH_FRONT || req_func == cdq_pkg::FUNC_PUSH_REAR))
      |=> held_ff == $past(held_ff) + CW'(1))
      else $error("successful push did not raise the count");

   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted request lost before the read stage");

   a_fwd_nonempty: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && (s1_ff.head_fwd || s1_ff.tail_fwd)) |-> s1_ff.held != '0)
      else $error("forwarded slot with an empty deque");
`endif

endmodule

// ===== hdl/cdq_ram.sv =====
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   import cdq_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic              ok;
      logic [CAP_W-1:0]  count;
      logic              is_empty;
      logic              is_full;
      logic [DATA_W-1:0] head_value;
      logic [DATA_W-1:0] tail_value;
   } deque_status_t;

   // mirror of the ring and its pointers, plus the queue of statuses still owed
   class deque_tracker;
      logic [DATA_W-1:0] ring [DEPTH_DEFAULT];
      logic [3:0]        front_gap;
      logic [3:0]        rear_gap;
      logic [CAP_W-1:0]  held;
      logic [CAP_W-1:0]  cap_reg;
      deque_status_t     pending_status [$];
      int unsigned       mismatches;
      int unsigned       requests_seen;
      int unsigned       results_seen;
      int unsigned       full_hits;
      int unsigned       refused_pushes;
      int unsigned       refused_pops;
      int unsigned       func_seen [8];

      function new();
         for (int i = 0; i < DEPTH_DEFAULT; i++) ring[i] = '0;
         for (int i = 0; i < 8; i++) func_seen[i] = 0;
         mismatches = 0;
         requests_seen = 0;
         results_seen = 0;
         full_hits = 0;
         refused_pushes = 0;
         refused_pops = 0;
         cap_reg = CAP_RESET;
         clear_ring();
      endfunction

      // zero reads as one slot, anything past the built depth saturates
      function int unsigned live_cap();
         int unsigned c;
         c = cap_reg;
         if (c == 0) c = 1;
         if (c > DEPTH_DEFAULT) c = DEPTH_DEFAULT;
         return c;
      endfunction

      function void clear_ring();
         front_gap = 4'(live_cap() - 1);
         rear_gap = 4'd0;
         held = '0;
      endfunction

      function logic [3:0] step_fwd(logic [3:0] i, int unsigned c);
         return (i + 1 >= c) ? 4'd0 : i + 4'd1;
      endfunction

      function logic [3:0] step_back(logic [3:0] i, int unsigned c);
         return (i == 0 || i >= c) ? 4'(c - 1) : i - 4'd1;
      endfunction

      function void set_capacity(logic [CSR_DATA_W-1:0] v);
         cap_reg = v[CAP_W-1:0];
         clear_ring();
      endfunction

      function void note_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
         int unsigned   c;
         deque_status_t s;
         c = live_cap();
         s = '0;
         requests_seen++;
         func_seen[f]++;
         case (f)
            FUNC_PUSH_FRONT: begin
               if (held < c) begin
                  ring[front_gap] = v;
                  front_gap = step_back(front_gap, c);
                  held++;
                  s.ok = 1'b1;
               end
            end
            FUNC_PUSH_REAR: begin
               if (held < c) begin
                  ring[rear_gap] = v;
                  rear_gap = step_fwd(rear_gap, c);
                  held++;
                  s.ok = 1'b1;
               end
            end
            FUNC_POP_FRONT: begin
               if (held != 0) begin
                  front_gap = step_fwd(front_gap, c);
                  held--;
                  s.ok = 1'b1;
               end
            end
            FUNC_POP_REAR: begin
               if (held != 0) begin
                  rear_gap = step_back(rear_gap, c);
                  held--;
                  s.ok = 1'b1;
               end
            end
            FUNC_QUERY: s.ok = 1'b1;
            default: ;
         endcase
         if (!s.ok && (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_REAR)) refused_pushes++;
         if (!s.ok && (f == FUNC_POP_FRONT || f == FUNC_POP_REAR)) refused_pops++;
         s.count = held;
         s.is_empty = (held == 0);
         s.is_full = (held == c);
         if (s.is_full) full_hits++;
         if (held == 0) begin
            s.head_value = EMPTY_VALUE;
            s.tail_value = EMPTY_VALUE;
         end else begin
            s.head_value = ring[step_fwd(front_gap, c)];
            s.tail_value = ring[step_back(rear_gap, c)];
         end
         pending_status.push_back(s);
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_response(deque_status_t got);
         deque_status_t want;
         results_seen++;
         if (pending_status.size() == 0) begin
            report("result transfer with no request outstanding");
            return;
         end
         want = pending_status.pop_front();
         if (got.ok !== want.ok)
            report($sformatf("ok %0b, wanted %0b", got.ok, want.ok));
         if (got.count !== want.count)
            report($sformatf("count %0d, wanted %0d", got.count, want.count));
         if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty %0b, wanted %0b", got.is_empty, want.is_empty));
         if (got.is_full !== want.is_full)
            report($sformatf("is_full %0b, wanted %0b", got.is_full, want.is_full));
         if (got.head_value !== want.head_value)
            report($sformatf("head_value %h, wanted %h", got.head_value, want.head_value));
         if (got.tail_value !== want.tail_value)
            report($sformatf("tail_value %h, wanted %h", got.tail_value, want.tail_value));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_ok;
   logic [CAP_W-1:0]         rsp_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic signed [DATA_W-1:0] rsp_head_value;
   logic signed [DATA_W-1:0] rsp_tail_value;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   deque_tracker tracker;
   bit           no_idle = 1'b0;
   int unsigned  rsp_hold_len = 0;
   int unsigned  caps_tried = 0;
   int unsigned  cycle_count = 0;

   circular_deque u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_head_value (rsp_head_value),
      .rsp_tail_value (rsp_tail_value),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // request noted before result check so a same-edge pair keeps its order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_request(req_func, req_value);
         if (rsp_valid && rsp_ready)
            tracker.check_response({rsp_ok, rsp_count, rsp_is_empty, rsp_is_full,
                                    rsp_head_value, rsp_tail_value});
      end
   end

   function automatic int unsigned idle_len();
      return no_idle ? 0 : $urandom_range(0, 16);
   endfunction

   // result side: a stall per transfer, plus any long hold asked for
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_len() + rsp_hold_len;
         rsp_hold_len = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
      int unsigned gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait for every owed result, then idle past the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CSR_DATA_W-1:0] v);
      logic [CSR_DATA_W-1:0] seen;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({REG_CAPACITY, 2'b00});
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.set_capacity(v);
      // read back straight after the write
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      seen = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (seen[CAP_W-1:0] !== v[CAP_W-1:0])
         tracker.report($sformatf("capacity reads %0d, wrote %0d",
                                  seen[CAP_W-1:0], v[CAP_W-1:0]));
      caps_tried++;
   endtask

   // fill-leaning and drain-leaning stretches so full and empty both come up
   task automatic run_random(int unsigned n, int unsigned hold);
      int unsigned       bias;
      int unsigned       r;
      logic [FUNC_W-1:0] f;
      logic [DATA_W-1:0] v;
      bias = 50;
      if (hold > 0) begin
         no_idle = 1'b1;
         rsp_hold_len = hold;
      end
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 24 == 0)
            bias = $urandom_range(0, 1) ? $urandom_range(65, 90) : $urandom_range(10, 35);
         if (hold > 0 && i < 60) bias = 85;
         else if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < bias)
            f = $urandom_range(0, 1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
         else if (r < 94)
            f = $urandom_range(0, 1) ? FUNC_POP_REAR : FUNC_POP_FRONT;
         else
            f = FUNC_W'($urandom_range(FUNC_QUERY, 7));
         case ($urandom_range(0, 9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = EMPTY_VALUE;
            3:       v = '0;
            default: v = $urandom;
         endcase
         send_request(f, v);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] cap_plan [13];
      tracker = new();
      cap_plan = '{32'd1, 32'd0, 32'd31, 32'd17, 32'd2, 32'hA5A5_A5E3, 32'd16,
                   32'd5, 32'd8, 32'd15, 32'd4, 32'd0, 32'd0};
      cap_plan[11] = $urandom_range(1, 16);
      cap_plan[12] = $urandom_range(1, 16);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset capacity, starting from empty
      send_request(FUNC_QUERY, 32'h1234_5678);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(3'd5, 32'hFFFF_FFFF);
      send_request(3'd6, '0);
      send_request(3'd7, 32'h5555_AAAA);
      send_request(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(FUNC_PUSH_REAR, 32'h8000_0000);
      send_request(FUNC_PUSH_FRONT, EMPTY_VALUE);
      send_request(FUNC_PUSH_REAR, '0);
      send_request(3'd7, 32'hDEAD_0001);
      send_request(FUNC_QUERY, '0);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_PUSH_REAR, 32'h1234_5678);
      send_request(FUNC_POP_FRONT, '0);

      // single slot: push into full is refused, pop from empty is refused
      settle();
      write_capacity(32'd1);
      send_request(FUNC_PUSH_FRONT, 32'hCAFE_0001);
      send_request(FUNC_PUSH_REAR, 32'hCAFE_0002);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_FRONT, '0);

      for (int k = 0; k < 13; k++) begin
         settle();
         if (k != 0) write_capacity(cap_plan[k]);
         run_random(100, (k == 6) ? 150 : 0);
      end
      settle();

      if (tracker.pending_status.size() != 0)
         tracker.report($sformatf("%0d results never arrived", tracker.pending_status.size()));
      $display("run: %0d requests, %0d results checked, %0d capacity writes",
               tracker.requests_seen, tracker.results_seen, caps_tried);
      $display("deque full %0d times, %0d pushes and %0d pops refused, %0d unknown codes",
               tracker.full_hits, tracker.refused_pushes, tracker.refused_pops,
               tracker.func_seen[5] + tracker.func_seen[6] + tracker.func_seen[7]);
      if (tracker.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
